>>> sv/c3cf_pkg.sv
// ----------------------------------------------------------------------------
// c3cf_pkg: shared types and constants of the 3x3 clamp filter
// Pixel, window and coefficient types, register map and reset values.
// ----------------------------------------------------------------------------
package c3cf_pkg;

    localparam int PIX_BITS      = 8;
    localparam int COEF_BITS     = 16;
    localparam int ROW_BITS      = 48;
    localparam int KERNEL_SIZE   = 3;
    localparam int WIN_TAPS      = KERNEL_SIZE * KERNEL_SIZE;
    localparam int WIDTH_BITS    = 11;
    localparam int HEIGHT_BITS   = 12;
    localparam int APB_ADDR_BITS = 6;
    localparam int APB_DATA_BITS = 64;
    localparam int PROD_BITS     = PIX_BITS + 1 + COEF_BITS;
    localparam int SUM_BITS      = PROD_BITS + 4;
    localparam int FRAC_BITS     = 8;
    localparam int MIN_DIM       = 3;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_COEF_TOP     = 3'd2;
    localparam logic [2:0] REG_COEF_MID     = 3'd3;
    localparam logic [2:0] REG_COEF_BOTTOM  = 3'd4;

    localparam logic [WIDTH_BITS-1:0]  RST_IMAGE_WIDTH  = 11'd512;
    localparam logic [HEIGHT_BITS-1:0] RST_IMAGE_HEIGHT = 12'd512;
    localparam logic [ROW_BITS-1:0]    RST_COEF_TOP     = 48'h0;
    localparam logic [ROW_BITS-1:0]    RST_COEF_MID     = 48'h0000_0100_0000;
    localparam logic [ROW_BITS-1:0]    RST_COEF_BOTTOM  = 48'h0;

    localparam logic [PIX_BITS-1:0] PIX_MAX = 8'd255;

    typedef logic [PIX_BITS-1:0] t_pix;
    typedef t_pix [WIN_TAPS-1:0] t_win;
    typedef logic [ROW_BITS-1:0] t_coef_row;

    typedef struct packed {
        logic [WIDTH_BITS-1:0]  image_width;
        logic [HEIGHT_BITS-1:0] image_height;
        t_coef_row              coef_top;
        t_coef_row              coef_mid;
        t_coef_row              coef_bottom;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic eof;
    } t_kern_in;

endpackage

>>> sv/c3cf_regs.sv
// ----------------------------------------------------------------------------
// c3cf_regs: configuration register file
// APB-style write and read of frame size and kernel coefficient rows.
// ----------------------------------------------------------------------------
module c3cf_regs
    import c3cf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output t_cfg                     o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[APB_ADDR_BITS-1:3];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= RST_IMAGE_WIDTH;
            r_cfg.image_height <= RST_IMAGE_HEIGHT;
            r_cfg.coef_top     <= RST_COEF_TOP;
            r_cfg.coef_mid     <= RST_COEF_MID;
            r_cfg.coef_bottom  <= RST_COEF_BOTTOM;
        end else if (wr_en) begin
            unique case (reg_index)
                REG_IMAGE_WIDTH:  r_cfg.image_width  <= pwdata[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT: r_cfg.image_height <= pwdata[HEIGHT_BITS-1:0];
                REG_COEF_TOP:     r_cfg.coef_top     <= pwdata[ROW_BITS-1:0];
                REG_COEF_MID:     r_cfg.coef_mid     <= pwdata[ROW_BITS-1:0];
                REG_COEF_BOTTOM:  r_cfg.coef_bottom  <= pwdata[ROW_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_BITS'(r_cfg.image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_BITS'(r_cfg.image_height);
            REG_COEF_TOP:     prdata = APB_DATA_BITS'(r_cfg.coef_top);
            REG_COEF_MID:     prdata = APB_DATA_BITS'(r_cfg.coef_mid);
            REG_COEF_BOTTOM:  prdata = APB_DATA_BITS'(r_cfg.coef_bottom);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/c3cf_kernel.sv
// ----------------------------------------------------------------------------
// c3cf_kernel: multiply, accumulate and clamp
// Registers nine pixel-coefficient products, then sums, floors and clamps
// into the result register.
// ----------------------------------------------------------------------------
module c3cf_kernel
    import c3cf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_kern_in  i_ctl,
    input  t_win      i_win,
    input  t_cfg      i_cfg,
    output logic      o_ready,
    output logic      o_valid,
    input  logic      i_stall,
    output t_pix      o_filtered_value,
    output logic      o_end_of_frame
);

    logic signed [PROD_BITS-1:0] r_prod [WIN_TAPS];
    logic signed [PROD_BITS-1:0] n_prod [WIN_TAPS];
    logic                        r_s3_valid;
    logic                        r_s3_eof;
    logic                        r_o_valid;
    t_pix                        r_o_value;
    logic                        r_o_eof;
    logic signed [SUM_BITS-1:0]  sum;
    t_pix                        clamped;
    logic                        out_ready;
    logic                        load;
    logic                        s3_adv;
    t_coef_row                   rows [KERNEL_SIZE];

    assign out_ready = !r_o_valid || !i_stall;
    assign o_ready   = !r_s3_valid || out_ready;
    assign load      = i_ctl.valid && o_ready;
    assign s3_adv    = r_s3_valid && out_ready;

    assign rows[0] = i_cfg.coef_top;
    assign rows[1] = i_cfg.coef_mid;
    assign rows[2] = i_cfg.coef_bottom;

    always_comb begin
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            for (int c = 0; c < KERNEL_SIZE; c++) begin
                n_prod[r*KERNEL_SIZE+c] =
                    $signed({1'b0, i_win[r*KERNEL_SIZE+c]})
                    * $signed(rows[r][c*COEF_BITS +: COEF_BITS]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_prod   <= n_prod;
            r_s3_eof <= i_ctl.eof;
        end
    end

    always_comb begin
        sum = '0;
        for (int i = 0; i < WIN_TAPS; i++) begin
            sum = sum + SUM_BITS'(r_prod[i]);
        end
    end

    always_comb begin
        priority if (sum[SUM_BITS-1]) begin
            clamped = '0;
        end else if (|sum[SUM_BITS-2:FRAC_BITS+PIX_BITS]) begin
            clamped = PIX_MAX;
        end else begin
            clamped = sum[FRAC_BITS+PIX_BITS-1:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (load) begin
                r_s3_valid <= 1'b1;
            end else if (s3_adv) begin
                r_s3_valid <= 1'b0;
            end
            if (s3_adv) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_adv) begin
            r_o_value <= clamped;
            r_o_eof   <= r_s3_eof;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_filtered_value = r_o_value;
    assign o_end_of_frame   = r_o_eof;

endmodule

>>> sv/conv3x3_clamp_filter_unit.sv
// ----------------------------------------------------------------------------
// conv3x3_clamp_filter_unit: streaming 3x3 convolution with clamp
// Pipeline: line store read at the pixel transfer, then window update,
// product register, result register; a downstream stall can hold each step.
// Throughput: one pixel per cycle while the output is not stalled; set by
// the single line store port pair.
// Reset: position counters and pipeline valids clear, registers take their
// defaults; line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module conv3x3_clamp_filter_unit
    import c3cf_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [PIX_BITS-1:0]      i_pixel_value,
    input  logic                     i_start_of_frame,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [PIX_BITS-1:0]      o_filtered_value,
    output logic                     o_end_of_frame,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int CW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
    localparam int WW = (CW + 1 > WIDTH_BITS) ? CW + 1 : WIDTH_BITS;

    t_cfg                   cfg;
    t_pix                   mem_up [MAX_LINE_WIDTH];
    t_pix                   mem_lo [MAX_LINE_WIDTH];

    logic [CW-1:0]          r_cc;
    logic [HEIGHT_BITS-1:0] r_rc;
    logic [CW-1:0]          n_cc;
    logic [HEIGHT_BITS-1:0] n_rc;
    logic [CW-1:0]          cc_cur;
    logic [HEIGHT_BITS-1:0] rc_cur;
    logic [WW-1:0]          w_eff;
    logic [HEIGHT_BITS-1:0] h_eff;
    logic [WW-1:0]          cc_inc;
    logic [HEIGHT_BITS:0]   rc_inc;
    logic                   produce;
    logic                   last_px;

    logic                   accept_in;
    logic                   s1_adv;
    logic                   s2_ready;
    logic                   kern_ready;
    logic                   hit;

    logic                   r_s1_valid;
    t_pix                   r_s1_pix;
    logic [CW-1:0]          r_s1_col;
    logic                   r_s1_prod;
    logic                   r_s1_eof;
    logic                   r_s1_hit;
    t_pix                   r_s1_fwd_up;
    t_pix                   r_s1_fwd_lo;
    t_pix                   r_rd_up;
    t_pix                   r_rd_lo;
    t_pix                   up_eff;
    t_pix                   lo_eff;

    t_win                   r_win;
    logic                   r_s2_valid;
    logic                   r_s2_eof;
    t_kern_in               kern_in;

    c3cf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    always_comb begin
        priority if (cfg.image_width < WIDTH_BITS'(MIN_DIM)) begin
            w_eff = WW'(MIN_DIM);
        end else if (WW'(cfg.image_width) > WW'(MAX_LINE_WIDTH)) begin
            w_eff = WW'(MAX_LINE_WIDTH);
        end else begin
            w_eff = WW'(cfg.image_width);
        end
        h_eff = (cfg.image_height < HEIGHT_BITS'(MIN_DIM)) ? HEIGHT_BITS'(MIN_DIM)
                                                           : cfg.image_height;
    end

    assign cc_cur = i_start_of_frame ? '0 : r_cc;
    assign rc_cur = i_start_of_frame ? '0 : r_rc;

    assign produce = (WW'(cc_cur) >= WW'(2)) && (rc_cur >= HEIGHT_BITS'(2))
                     && (WW'(cc_cur) < w_eff) && (rc_cur < h_eff);
    assign last_px = (WW'(cc_cur) == w_eff - WW'(1)) && (rc_cur == h_eff - HEIGHT_BITS'(1));

    assign cc_inc = WW'(cc_cur) + WW'(1);
    assign rc_inc = {1'b0, rc_cur} + (HEIGHT_BITS+1)'(1);

    always_comb begin
        if (cc_inc >= w_eff) begin
            n_cc = '0;
            n_rc = (rc_inc >= {1'b0, h_eff}) ? '0 : rc_inc[HEIGHT_BITS-1:0];
        end else begin
            n_cc = cc_inc[CW-1:0];
            n_rc = rc_cur;
        end
    end

    assign s2_ready  = !r_s2_valid || kern_ready;
    assign s1_adv    = r_s1_valid && s2_ready;
    assign o_stall   = r_s1_valid && !s1_adv;
    assign accept_in = i_valid && !o_stall;

    assign up_eff = r_s1_hit ? r_s1_fwd_up : r_rd_up;
    assign lo_eff = r_s1_hit ? r_s1_fwd_lo : r_rd_lo;
    assign hit    = s1_adv && (r_s1_col == cc_cur);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc <= '0;
            r_rc <= '0;
        end else if (accept_in) begin
            r_cc <= n_cc;
            r_rc <= n_rc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_rd_up <= mem_up[cc_cur];
        end
        if (s1_adv) begin
            mem_up[r_s1_col] <= lo_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_rd_lo <= mem_lo[cc_cur];
        end
        if (s1_adv) begin
            mem_lo[r_s1_col] <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_s1_pix    <= i_pixel_value;
            r_s1_col    <= cc_cur;
            r_s1_prod   <= produce;
            r_s1_eof    <= last_px;
            r_s1_hit    <= hit;
            r_s1_fwd_up <= lo_eff;
            r_s1_fwd_lo <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                r_win[r*KERNEL_SIZE]     <= r_win[r*KERNEL_SIZE+1];
                r_win[r*KERNEL_SIZE+1]   <= r_win[r*KERNEL_SIZE+2];
            end
            r_win[2]  <= up_eff;
            r_win[5]  <= lo_eff;
            r_win[8]  <= r_s1_pix;
            r_s2_eof  <= r_s1_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (accept_in) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_valid <= r_s1_prod;
            end else if (kern_ready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    assign kern_in.valid = r_s2_valid;
    assign kern_in.eof   = r_s2_eof;

    c3cf_kernel u_kernel (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (kern_in),
        .i_win            (r_win),
        .i_cfg            (cfg),
        .o_ready          (kern_ready),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_filtered_value (o_filtered_value),
        .o_end_of_frame   (o_end_of_frame)
    );

endmodule
